### src/dwpsc_pkg.sv
// ----------------------------------------------------------------------------
// dwpsc_pkg
// Shared types and constants of the dual wheel PWM speed controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dwpsc_pkg;

  localparam int SPEED_W = 16;
  localparam int PWM_W   = 10;
  localparam int ERR_W   = SPEED_W + 1;
  // 100 * 65535 fits in 23 bits
  localparam int DVD_W   = 23;
  localparam int IDX_W   = 3;

  localparam logic [PWM_W-1:0] EQ_CAP     = PWM_W'(256);
  localparam logic [PWM_W-1:0] TURN_UP    = PWM_W'(6);
  localparam logic [PWM_W-1:0] TURN_DOWN  = PWM_W'(2);
  localparam logic [PWM_W-1:0] STOP_DOWN  = PWM_W'(8);
  localparam logic signed [ERR_W-1:0] RAISE_THR = ERR_W'(5);
  localparam logic signed [ERR_W-1:0] LOWER_THR = -ERR_W'(10);

  typedef enum logic [IDX_W-1:0] {
    REG_FULL_SCALE    = 3'd0,
    REG_START_SPEED   = 3'd1,
    REG_PWM_RANGE     = 3'd2,
    REG_BOOST_PWM     = 3'd3,
    REG_MIN_MOTOR_PWM = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD
  } state_t;

  // Settings the per-wheel update logic needs
  typedef struct packed {
    logic [SPEED_W-1:0] start_speed;
    logic [PWM_W-1:0]   pwm_range;
    logic [PWM_W-1:0]   boost_pwm;
    logic [PWM_W-1:0]   min_motor_pwm;
  } wheel_cfg_t;

  // Per-tick flags shared by both wheels
  typedef struct packed {
    logic turning;
    logic both_zero;
  } tick_ctl_t;

endpackage

`default_nettype wire

### src/dwpsc_div.sv
// ----------------------------------------------------------------------------
// dwpsc_div
// Restoring divider, one quotient bit per cycle through a shift register.
// ----------------------------------------------------------------------------
`default_nettype none

module dwpsc_div #(
  parameter int DVD_W = 23,
  parameter int DVS_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] rem_nxt;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  always_comb begin
    trial   = {rem_r, quo_r[DVD_W-1]};
    diff    = trial - {1'b0, divisor};
    ge      = (trial >= {1'b0, divisor});
    // remainder stays below the divisor, so it fits DVS_W bits either way
    rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift dividend bits out at the top, quotient bits in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

### src/dwpsc_wheel.sv
// ----------------------------------------------------------------------------
// dwpsc_wheel
// Duty update of one wheel: step selection, start boost, raise, lower, cutoff.
// ----------------------------------------------------------------------------
`default_nettype none

module dwpsc_wheel (
  input  wire dwpsc_pkg::wheel_cfg_t                   cfg,
  input  wire dwpsc_pkg::tick_ctl_t                    ctl,
  input  wire logic [dwpsc_pkg::PWM_W-1:0]             duty,
  input  wire logic [dwpsc_pkg::SPEED_W-1:0]           target,
  input  wire logic signed [dwpsc_pkg::ERR_W-1:0]      err,
  input  wire logic [dwpsc_pkg::DVD_W-1:0]             quo_up,
  input  wire logic [dwpsc_pkg::DVD_W-1:0]             quo_down,
  output logic [dwpsc_pkg::PWM_W-1:0]                  duty_new,
  output logic                                         boost
);

  logic [dwpsc_pkg::PWM_W-1:0] up;
  logic [dwpsc_pkg::PWM_W-1:0] down;
  logic [dwpsc_pkg::PWM_W:0]   sum;
  logic [dwpsc_pkg::PWM_W-1:0] d;

  always_comb begin
    // a step beyond the range counts as no step
    up   = (quo_up > dwpsc_pkg::DVD_W'(cfg.pwm_range)) ? '0
                                                         : quo_up[dwpsc_pkg::PWM_W-1:0];
    down = (quo_down > dwpsc_pkg::DVD_W'(cfg.pwm_range)) ? '0
                                                           : quo_down[dwpsc_pkg::PWM_W-1:0];
    if (ctl.turning) begin
      up   = dwpsc_pkg::TURN_UP;
      down = dwpsc_pkg::TURN_DOWN;
    end
    if (ctl.both_zero) begin
      down = dwpsc_pkg::STOP_DOWN;
    end

    sum   = {1'b0, duty} + {1'b0, up};
    d     = duty;
    boost = 1'b0;
    if (duty == '0 && target >= cfg.start_speed) begin
      d     = cfg.boost_pwm;
      boost = 1'b1;
    end else if (err > dwpsc_pkg::RAISE_THR) begin
      d = (sum > {1'b0, cfg.pwm_range}) ? cfg.pwm_range : sum[dwpsc_pkg::PWM_W-1:0];
    end else if (err < dwpsc_pkg::LOWER_THR) begin
      d = (duty > down) ? duty - down : '0;
    end

    // switch off a slow-target wheel below the motor's useful duty
    duty_new = (d < cfg.min_motor_pwm && target < cfg.start_speed) ? '0 : d;
  end

endmodule

`default_nettype wire

### src/dual_wheel_pwm_speed_controller.sv
// ----------------------------------------------------------------------------
// dual_wheel_pwm_speed_controller
// Two-wheel PWM duty regulator driven by per-tick target and measured speeds.
// ----------------------------------------------------------------------------
// Each input item carries target and measured speeds of wheels A and B plus a
// turning flag; the block returns one item with both new duties and the start
// boost flags. Items are handled one at a time. The four bit-serial dividers
// that scale the speed error by the full-scale speed load at the accepting
// edge and then take one quotient bit per cycle until all are done; the
// sequencer then leaves ST_DIV for ST_UPD, which writes the output register
// and so makes the result valid, and only after the return to ST_IDLE is the
// next item taken. A finished result waits in the output register while the
// next item is accepted; if it is still waiting when the next result is ready,
// the update and so the input stall until it is taken.
// Configuration writes are always taken and must only happen while no item is
// in flight.
`default_nettype none

module dual_wheel_pwm_speed_controller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,  // target_a, target_b, measured_a, measured_b
  input  wire logic        in_tuser,  // turning
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata, // drive_a, drive_b, boost_a, boost_b, zero pad
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int SW = dwpsc_pkg::SPEED_W;
  localparam int PW = dwpsc_pkg::PWM_W;
  localparam int EW = dwpsc_pkg::ERR_W;
  localparam int DW = dwpsc_pkg::DVD_W;

  // configuration registers
  logic [SW-1:0] full_scale_r;
  logic [SW-1:0] start_speed_r;
  logic [PW-1:0] pwm_range_r;
  logic [PW-1:0] boost_pwm_r;
  logic [PW-1:0] min_motor_pwm_r;

  dwpsc_pkg::state_t state_r, state_nxt;

  logic [PW-1:0]        duty_a_r, duty_b_r;
  logic [SW-1:0]        tgt_a_r, tgt_b_r;
  logic signed [EW-1:0] err_a_r, err_b_r;
  logic                 turning_r;

  logic          out_tvalid_r;
  logic [PW-1:0] out_drive_a_r, out_drive_b_r;
  logic          out_boost_a_r, out_boost_b_r;

  logic                 accept;
  logic                 upd;
  logic [SW-1:0]        tgt_a, tgt_b, meas_a, meas_b;
  logic signed [EW-1:0] err_a, err_b;
  logic [SW-1:0]        mag_a, mag_b;
  logic [DW-1:0]        up_dvd_a, dn_dvd_a, up_dvd_b, dn_dvd_b;
  logic [SW-1:0]        divisor;
  logic [DW-1:0]        q_up_a, q_dn_a, q_up_b, q_dn_b;
  logic                 dn_up_a, dn_dn_a, dn_up_b, dn_dn_b;
  logic                 div_done;

  dwpsc_pkg::wheel_cfg_t wcfg;
  dwpsc_pkg::tick_ctl_t  ctl;
  logic [PW-1:0]         eq_max, duty_a_eq, duty_b_eq;
  logic [PW-1:0]         new_a, new_b;
  logic                  boost_a, boost_b;

  assign in_tready = (state_r == dwpsc_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    tgt_a  = in_tdata[15:0];
    tgt_b  = in_tdata[31:16];
    meas_a = in_tdata[47:32];
    meas_b = in_tdata[63:48];
    err_a  = $signed({1'b0, tgt_a}) - $signed({1'b0, meas_a});
    err_b  = $signed({1'b0, tgt_b}) - $signed({1'b0, meas_b});
    // |err| is at most 65535
    mag_a  = err_a[EW-1] ? SW'(-err_a) : err_a[SW-1:0];
    mag_b  = err_b[EW-1] ? SW'(-err_b) : err_b[SW-1:0];
    // 100 = 64 + 32 + 4, 60 = 64 - 4
    up_dvd_a = (DW'(mag_a) << 6) + (DW'(mag_a) << 5) + (DW'(mag_a) << 2);
    dn_dvd_a = (DW'(mag_a) << 6) - (DW'(mag_a) << 2);
    up_dvd_b = (DW'(mag_b) << 6) + (DW'(mag_b) << 5) + (DW'(mag_b) << 2);
    dn_dvd_b = (DW'(mag_b) << 6) - (DW'(mag_b) << 2);
    divisor  = (full_scale_r == '0) ? SW'(1) : full_scale_r;
  end

  dwpsc_div #(.DVD_W(DW), .DVS_W(SW)) u_div_up_a (
    .clk(clk), .rst_n(rst_n), .start(accept), .dividend(up_dvd_a),
    .divisor(divisor), .done(dn_up_a), .quotient(q_up_a)
  );

  dwpsc_div #(.DVD_W(DW), .DVS_W(SW)) u_div_dn_a (
    .clk(clk), .rst_n(rst_n), .start(accept), .dividend(dn_dvd_a),
    .divisor(divisor), .done(dn_dn_a), .quotient(q_dn_a)
  );

  dwpsc_div #(.DVD_W(DW), .DVS_W(SW)) u_div_up_b (
    .clk(clk), .rst_n(rst_n), .start(accept), .dividend(up_dvd_b),
    .divisor(divisor), .done(dn_up_b), .quotient(q_up_b)
  );

  dwpsc_div #(.DVD_W(DW), .DVS_W(SW)) u_div_dn_b (
    .clk(clk), .rst_n(rst_n), .start(accept), .dividend(dn_dvd_b),
    .divisor(divisor), .done(dn_dn_b), .quotient(q_dn_b)
  );

  assign div_done = dn_up_a & dn_dn_a & dn_up_b & dn_dn_b;

  // equalize both wheels when both targets are zero
  always_comb begin
    ctl.turning   = turning_r;
    ctl.both_zero = (tgt_a_r == '0) && (tgt_b_r == '0);
    eq_max        = (duty_a_r > duty_b_r) ? duty_a_r : duty_b_r;
    if (eq_max > dwpsc_pkg::EQ_CAP) begin
      eq_max = dwpsc_pkg::EQ_CAP;
    end
    duty_a_eq = ctl.both_zero ? eq_max : duty_a_r;
    duty_b_eq = ctl.both_zero ? eq_max : duty_b_r;

    wcfg.start_speed   = start_speed_r;
    wcfg.pwm_range     = pwm_range_r;
    wcfg.boost_pwm     = boost_pwm_r;
    wcfg.min_motor_pwm = min_motor_pwm_r;
  end

  dwpsc_wheel u_wheel_a (
    .cfg(wcfg), .ctl(ctl), .duty(duty_a_eq), .target(tgt_a_r), .err(err_a_r),
    .quo_up(q_up_a), .quo_down(q_dn_a), .duty_new(new_a), .boost(boost_a)
  );

  dwpsc_wheel u_wheel_b (
    .cfg(wcfg), .ctl(ctl), .duty(duty_b_eq), .target(tgt_b_r), .err(err_b_r),
    .quo_up(q_up_b), .quo_down(q_dn_b), .duty_new(new_b), .boost(boost_b)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    upd       = 1'b0;
    case (state_r)
      dwpsc_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = dwpsc_pkg::ST_DIV;
        end
      end
      dwpsc_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = dwpsc_pkg::ST_UPD;
        end
      end
      dwpsc_pkg::ST_UPD: begin
        // hold until the output register is free
        if (!out_tvalid_r || out_tready) begin
          upd       = 1'b1;
          state_nxt = dwpsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dwpsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dwpsc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r    <= SW'(1000);
      start_speed_r   <= SW'(100);
      pwm_range_r     <= PW'(1023);
      boost_pwm_r     <= PW'(600);
      min_motor_pwm_r <= PW'(300);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dwpsc_pkg::REG_FULL_SCALE:    full_scale_r    <= cfg_data;
        dwpsc_pkg::REG_START_SPEED:   start_speed_r   <= cfg_data;
        dwpsc_pkg::REG_PWM_RANGE:     pwm_range_r     <= cfg_data[PW-1:0];
        dwpsc_pkg::REG_BOOST_PWM:     boost_pwm_r     <= cfg_data[PW-1:0];
        dwpsc_pkg::REG_MIN_MOTOR_PWM: min_motor_pwm_r <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_a_r     <= '0;
      duty_b_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (upd) begin
        duty_a_r     <= new_a;
        duty_b_r     <= new_b;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tgt_a_r   <= tgt_a;
      tgt_b_r   <= tgt_b;
      err_a_r   <= err_a;
      err_b_r   <= err_b;
      turning_r <= in_tuser;
    end
    if (upd) begin
      out_drive_a_r <= new_a;
      out_drive_b_r <= new_b;
      out_boost_a_r <= boost_a;
      out_boost_b_r <= boost_b;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_boost_b_r, out_boost_a_r, out_drive_b_r, out_drive_a_r};

endmodule

`default_nettype wire
